// ----- design/ipc_pkg.sv -----
// shared constants, types and status codes of the imu packet checker
`timescale 1ns / 1ps
package ipc_pkg;

  // packet geometry
  localparam int unsigned PKT_BYTES = 36;
  localparam int unsigned CRC_BYTES = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned OUT_W     = 200;

  // header constants and crc parameters
  localparam logic [31:0] PKT_MAGIC   = 32'h554D4955;
  localparam logic [15:0] PKT_VERSION = 16'd1;
  localparam logic [15:0] PKT_LENGTH  = 16'd36;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_LENGTH  = 3'd4,
    ST_BAD_CRC     = 3'd5
  } status_t;

  // control from the top level to the crc unit
  typedef struct packed {
    logic step;
    logic restart;
  } crc_ctrl_t;

endpackage

// ----- design/ipc_byte_cell.sv -----
// one byte cell of the capture chain
`timescale 1ns / 1ps
module ipc_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d_in,
  output logic [7:0] q,
  output logic [7:0] q_next
);

  // take the neighbor's byte while the chain shifts
  assign q_next = shift ? d_in : q;

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ----- design/ipc_crc_unit.sv -----
// reflected crc-32 accumulator, one byte per cycle while step is set
`timescale 1ns / 1ps
module ipc_crc_unit (
  input  logic                clk,
  input  logic                rst,
  input  ipc_pkg::crc_ctrl_t  ctrl,
  input  logic [7:0]          data_byte,
  output logic [31:0]         crc_next
);
  import ipc_pkg::*;

  logic [31:0] crc;

  // eight bit steps of the reflected polynomial
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // value after the current request, used by the status check
  assign crc_next = ctrl.step ? crc_byte(crc, data_byte) : crc;

  // accumulator, restarted after each datagram
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      crc <= CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

// ----- design/imu_packet_checker_core.sv -----
// top level of the imu packet checker: capture chain, crc and result register
//
// Input stream: one datagram byte per request on s_tdata, s_tlast on the
// final byte. The fixed 36-byte orientation packet is captured in a chain of
// 36 byte cells that shifts once per byte; bytes past the 36th are dropped.
// A reflected crc-32 over bytes 0..31 runs beside the chain, one byte a cycle while s_tready is high.
// Output stream: one result per datagram, issued for the request that
// carries s_tlast: status, sequence, timestamp and the three angle words.
// A datagram shorter than 36 bytes reports the short status with all other
// fields zero; otherwise the first failing check of magic, version, length
// field and crc gives the status.
// Throughput: one byte per cycle while s_tready is high. Latency: the result is valid in the cycle
// after the last byte is taken, from a single output register.
// Stall: non-final bytes are always taken; a final byte waits only while the
// output register holds a result that m_tready has not yet taken.
// Reset: rst clears the byte count, the crc and the output valid; the
// capture cells need no reset.
`timescale 1ns / 1ps
module imu_packet_checker_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,  // [7:0] data_byte
  input  logic                    s_tlast,  // last_byte
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [ipc_pkg::OUT_W-1:0] m_tdata // [2:0] status, [34:3] sequence_res,
                                            // [98:35] time_ns, [130:99] roll_bits,
                                            // [162:131] pitch_bits,
                                            // [194:163] yaw_bits, [199:195] zero
);
  import ipc_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_next;
  logic             in_acc;
  logic             shift;
  logic [7:0]       cell_in   [PKT_BYTES];
  logic [7:0]       cell_q    [PKT_BYTES];
  logic [7:0]       cell_next [PKT_BYTES];
  crc_ctrl_t        crc_ctrl;
  logic [31:0]      crc_next;
  logic [31:0]      magic_w;
  logic [15:0]      version_w;
  logic [15:0]      length_w;
  logic [31:0]      seq_w;
  logic [63:0]      stamp_w;
  logic [31:0]      roll_w;
  logic [31:0]      pitch_w;
  logic [31:0]      yaw_w;
  logic [31:0]      check_w;
  status_t          status;
  logic [OUT_W-1:0] result;
  logic             out_valid;

  // handshake: only a final byte needs room in the output register
  assign s_tready = !out_valid || m_tready || !s_tlast;
  assign in_acc   = s_tvalid && s_tready;
  assign shift    = in_acc && (count < CNT_W'(PKT_BYTES));

  // byte counter, saturating at the packet size
  assign count_inc  = shift ? count + CNT_W'(1) : count;
  assign count_next = (in_acc && s_tlast) ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // capture chain: byte j ends up in cell 35-j
  assign cell_in[0] = s_tdata;
  for (genvar k = 1; k < PKT_BYTES; k++) begin : g_link
    assign cell_in[k] = cell_q[k-1];
  end

  for (genvar k = 0; k < PKT_BYTES; k++) begin : g_cell
    ipc_byte_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .d_in   (cell_in[k]),
      .q      (cell_q[k]),
      .q_next (cell_next[k])
    );
  end

  // crc over the first 32 bytes
  assign crc_ctrl.step    = in_acc && (count < CNT_W'(CRC_BYTES));
  assign crc_ctrl.restart = in_acc && s_tlast;

  ipc_crc_unit u_crc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (crc_ctrl),
    .data_byte (s_tdata),
    .crc_next  (crc_next)
  );

  // little-endian fields, taken from the chain as it stands after this byte
  assign magic_w   = {cell_next[32], cell_next[33], cell_next[34], cell_next[35]};
  assign version_w = {cell_next[30], cell_next[31]};
  assign length_w  = {cell_next[28], cell_next[29]};
  assign seq_w     = {cell_next[24], cell_next[25], cell_next[26], cell_next[27]};
  assign stamp_w   = {cell_next[16], cell_next[17], cell_next[18], cell_next[19],
                      cell_next[20], cell_next[21], cell_next[22], cell_next[23]};
  assign roll_w    = {cell_next[12], cell_next[13], cell_next[14], cell_next[15]};
  assign pitch_w   = {cell_next[8],  cell_next[9],  cell_next[10], cell_next[11]};
  assign yaw_w     = {cell_next[4],  cell_next[5],  cell_next[6],  cell_next[7]};
  assign check_w   = {cell_next[0],  cell_next[1],  cell_next[2],  cell_next[3]};

  // status checks in priority order
  always_comb begin
    priority if (count_inc < CNT_W'(PKT_BYTES)) begin
      status = ST_SHORT;
    end else if (magic_w != PKT_MAGIC) begin
      status = ST_BAD_MAGIC;
    end else if (version_w != PKT_VERSION) begin
      status = ST_BAD_VERSION;
    end else if (length_w != PKT_LENGTH) begin
      status = ST_BAD_LENGTH;
    end else if (~crc_next != check_w) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // result word, fields zeroed for a short datagram
  always_comb begin
    if (status == ST_SHORT) begin
      result = {(OUT_W-3)'(0), status};
    end else begin
      result = {5'd0, yaw_w, pitch_w, roll_w, stamp_w, seq_w, status};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && s_tlast) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) begin
      m_tdata <= result;
    end
  end

  assign m_tvalid = out_valid;

endmodule
